// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion helpers shared by the serial port register block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/u8250_pkg.sv -----
// ----------------------------------------------------------------------------
// u8250_pkg
// types, register offsets and reset values of the 8250-style port registers
// ----------------------------------------------------------------------------
package u8250_pkg;

  localparam int NUM_PORTS  = 4;
  localparam int REQ_TYPE_W = 2;
  localparam int PORT_W     = 2;
  localparam int REG_IDX_W  = 3;
  localparam int DATA_W     = 8;
  localparam int DIV_W      = 16;

  localparam int ADDR_CLOG = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int ADDR_W    = (ADDR_CLOG > PORT_W) ? PORT_W : ADDR_CLOG;

  localparam logic [DIV_W-1:0] EXP_DIV_RESET = 16'd96;

  // transaction kinds
  localparam logic [REQ_TYPE_W-1:0] REQ_BUS_WR = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_BUS_RD = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_RX     = 2'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_MSI    = 2'd3;

  // register offsets
  localparam logic [REG_IDX_W-1:0] REG_RBR = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IIR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LCR = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MCR = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LSR = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MSR = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SCR = 3'd7;

  // interrupt identification codes
  localparam logic [2:0] IIR_NONE = 3'b001;
  localparam logic [2:0] IIR_RLS  = 3'b110;
  localparam logic [2:0] IIR_RDA  = 3'b100;
  localparam logic [2:0] IIR_THRE = 3'b010;
  localparam logic [2:0] IIR_MSR  = 3'b000;

  // pending source bits
  localparam int PEND_RDA  = 0;
  localparam int PEND_THRE = 1;
  localparam int PEND_RLS  = 2;
  localparam int PEND_MSR  = 3;

  // register bits
  localparam int LCR_DLAB = 7;
  localparam int MCR_OUT2 = 3;
  localparam int MCR_LOOP = 4;
  localparam int LSR_DR   = 0;
  localparam int LSR_OE   = 1;
  localparam int LSR_FE   = 3;

  localparam logic [7:0] LSR_RESET    = 8'h60;
  localparam logic [7:0] LSR_THR_IDLE = 8'h20;
  localparam logic [7:0] LSR_ERR_MASK = 8'h1f;
  localparam logic [7:0] LSR_ERR_CLR  = 8'he1;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [PORT_W-1:0]     port;
    logic [REG_IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0]     data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_update;
    logic              irq_level;
    logic              modem_ctrl_valid;
    logic [DATA_W-1:0] modem_ctrl_out;
  } rsp_t;

  typedef struct packed {
    logic [7:0] div_lo;
    logic [7:0] div_hi;
    logic [7:0] ier;
    logic [2:0] iir;
    logic [7:0] lcr;
    logic [7:0] mcr;
    logic [7:0] lsr;
    logic [7:0] msr;
    logic [7:0] scr;
    logic [7:0] rbr;
    logic [3:0] pend;
  } port_state_t;

  localparam port_state_t PORT_RESET = '{
    div_lo: 8'h00, div_hi: 8'h00, ier: 8'h00, iir: IIR_NONE,
    lcr: 8'h00, mcr: 8'h00, lsr: LSR_RESET, msr: 8'h00,
    scr: 8'h00, rbr: 8'h00, pend: 4'h0
  };

endpackage

// ----- hdl/u8250_req_if.sv -----
// ----------------------------------------------------------------------------
// u8250_req_if
// request channel: bus accesses, received bytes and modem line changes
// ----------------------------------------------------------------------------
interface u8250_req_if import u8250_pkg::*;;

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [PORT_W-1:0]     port;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [DATA_W-1:0]     data;

  modport source (output valid, output req_type, output port, output reg_index,
                  output data, input ready);
  modport sink (input valid, input req_type, input port, input reg_index,
                input data, output ready);

endinterface

// ----- hdl/u8250_rsp_if.sv -----
// ----------------------------------------------------------------------------
// u8250_rsp_if
// result channel: read data, interrupt line update and modem control output
// ----------------------------------------------------------------------------
interface u8250_rsp_if import u8250_pkg::*;;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_update;
  logic              irq_level;
  logic              modem_ctrl_valid;
  logic [DATA_W-1:0] modem_ctrl_out;

  modport source (output valid, output read_data, output irq_update,
                  output irq_level, output modem_ctrl_valid, output modem_ctrl_out,
                  input ready);
  modport sink (input valid, input read_data, input irq_update,
                input irq_level, input modem_ctrl_valid, input modem_ctrl_out,
                output ready);

endinterface

// ----- hdl/uart_8250_register_interrupt_model.sv -----
// ----------------------------------------------------------------------------
// uart_8250_register_interrupt_model
// path: an accepted transaction passes stage 1 and the output register to out_if
// throughput: one transaction per cycle unless out_if stalls, any mix of ports,
//   set by the single read and write port of the per-port register memory
// reset: all ports read as their reset values; expected divisor returns to 96
// ----------------------------------------------------------------------------
module uart_8250_register_interrupt_model import u8250_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  u8250_req_if.sink         in_if,
  u8250_rsp_if.source       out_if,
  input  logic              cfg_wr_en,
  input  logic [DIV_W-1:0]  cfg_wr_data
);

`include "assert_macros.svh"

  // configuration
  logic [DIV_W-1:0] exp_div_r;

  // register memory, one entry per port, plus per-entry written flags
  port_state_t      port_mem [NUM_PORTS];
  logic [NUM_PORTS-1:0] entry_vld_r;
  port_state_t      rd_data_r;
  logic             rd_entry_vld_r;

  // stage 1: transaction waiting on its memory read
  logic             s1_vld_r;
  req_t             s1_req_r;

  // last write-back, forwarded to a following transaction on the same port
  logic             wb_vld_r;
  logic [ADDR_W-1:0] wb_addr_r;
  port_state_t      wb_data_r;

  // output register
  logic             out_valid_r;
  rsp_t             out_rsp_r;

  logic             in_acc;
  logic             out_free;
  logic             s1_adv;
  logic             s1_in_range;
  logic             mem_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] s1_addr;
  port_state_t      cur_state;
  port_state_t      nxt_state;
  rsp_t             upd_rsp;
  rsp_t             s1_rsp;
  req_t             in_req;

  assign in_req = '{req_type: in_if.req_type, port: in_if.port,
                    reg_index: in_if.reg_index, data: in_if.data};

  // handshake: stage 1 drains into the output register whenever it is free
  assign out_free    = !out_valid_r || out_if.ready;
  assign s1_adv      = s1_vld_r && out_free;
  assign in_if.ready = !s1_vld_r || out_free;
  assign in_acc      = in_if.valid && in_if.ready;

  assign rd_addr     = in_if.port[ADDR_W-1:0];
  assign s1_addr     = s1_req_r.port[ADDR_W-1:0];
  assign s1_in_range = int'(s1_req_r.port) < NUM_PORTS;
  assign mem_we      = s1_adv && s1_in_range;

  // current entry: forwarded write-back, else memory, else reset value
  always_comb begin
    if (wb_vld_r && (wb_addr_r == s1_addr)) begin
      cur_state = wb_data_r;
    end else if (rd_entry_vld_r) begin
      cur_state = rd_data_r;
    end else begin
      cur_state = PORT_RESET;
    end
  end

  u8250_port_upd u_upd (
    .cur     (cur_state),
    .req     (s1_req_r),
    .exp_div (exp_div_r),
    .nxt     (nxt_state),
    .rsp     (upd_rsp)
  );

  // out-of-range port gives an all-zero result
  assign s1_rsp = s1_in_range ? upd_rsp : '0;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_div_r <= EXP_DIV_RESET;
    end else if (cfg_wr_en) begin
      exp_div_r <= cfg_wr_data;
    end
  end

  // memory read on accept, write-back as stage 1 retires
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r      <= port_mem[rd_addr];
      rd_entry_vld_r <= entry_vld_r[rd_addr];
    end
    if (mem_we) begin
      port_mem[s1_addr] <= nxt_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      wb_vld_r    <= 1'b0;
    end else if (mem_we) begin
      entry_vld_r[s1_addr] <= 1'b1;
      wb_vld_r             <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wb_addr_r <= s1_addr;
      wb_data_r <= nxt_state;
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_req;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rsp_r <= s1_rsp;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.read_data        = out_rsp_r.read_data;
  assign out_if.irq_update       = out_rsp_r.irq_update;
  assign out_if.irq_level        = out_rsp_r.irq_level;
  assign out_if.modem_ctrl_valid = out_rsp_r.modem_ctrl_valid;
  assign out_if.modem_ctrl_out   = out_rsp_r.modem_ctrl_out;

  // checks
  `ASSERT_IMP(a_stall_blocks_in, s1_vld_r && !out_free, !in_if.ready, "input taken while stage 1 stalled")
  `ASSERT_IMP(a_wr_on_retire, mem_we, s1_vld_r && out_free, "write-back without retiring transaction")
  `ASSERT_IMP(a_level_needs_upd, out_valid_r && out_rsp_r.irq_level, out_rsp_r.irq_update, "irq level without update")
  `ASSERT_NXT(a_accept_loads, in_acc, s1_vld_r, "accepted transaction lost before stage 1")
  `ASSERT_NXT(a_retire_shows, s1_adv, out_valid_r, "retired transaction missing at output")

endmodule

// ----- hdl/u8250_port_upd.sv -----
// ----------------------------------------------------------------------------
// u8250_port_upd
// next register state and result of one port for one transaction
// ----------------------------------------------------------------------------
module u8250_port_upd import u8250_pkg::*; (
  input  port_state_t      cur,
  input  req_t             req,
  input  logic [DIV_W-1:0] exp_div,
  output port_state_t      nxt,
  output rsp_t             rsp
);

  logic       dlab;
  logic       eval;
  logic [7:0] lsr_v;
  logic [7:0] msr_v;
  logic [3:0] msr_chg;
  logic [3:0] act;

  assign dlab    = cur.lcr[LCR_DLAB];
  assign msr_chg = cur.msr[7:4] ^ req.data[7:4];

  always_comb begin
    nxt   = cur;
    eval  = 1'b0;
    lsr_v = 8'h00;
    msr_v = 8'h00;
    act   = 4'h0;
    rsp   = '0;
    unique case (req.req_type)
      REQ_BUS_WR: begin
        unique case (req.reg_index)
          REG_RBR: begin
            if (dlab) begin
              nxt.div_lo = req.data;
            end else begin
              // loopback: transmitted byte lands in the receiver
              if (cur.mcr[MCR_LOOP]) begin
                nxt.lsr[LSR_DR] = 1'b1;
                nxt.rbr         = req.data;
              end
              nxt.pend[PEND_THRE] = 1'b0;
              eval                = 1'b1;
            end
          end
          REG_IER: begin
            if (dlab) begin
              nxt.div_hi = req.data;
            end else begin
              nxt.ier = req.data;
            end
          end
          REG_LCR: nxt.lcr = req.data;
          REG_MCR: begin
            nxt.mcr              = req.data;
            rsp.modem_ctrl_valid = 1'b1;
            rsp.modem_ctrl_out   = req.data;
          end
          REG_SCR: nxt.scr = req.data;
          default: ;
        endcase
      end
      REQ_BUS_RD: begin
        unique case (req.reg_index)
          REG_RBR: begin
            if (dlab) begin
              rsp.read_data = cur.div_lo;
            end else begin
              rsp.read_data      = cur.rbr;
              nxt.lsr[LSR_DR]    = 1'b0;
              nxt.pend[PEND_RDA] = 1'b0;
              eval               = 1'b1;
            end
          end
          REG_IER: rsp.read_data = dlab ? cur.div_hi : cur.ier;
          REG_IIR: begin
            rsp.read_data       = {5'b0, cur.iir};
            nxt.pend[PEND_THRE] = 1'b0;
            eval                = 1'b1;
          end
          REG_LCR: rsp.read_data = cur.lcr;
          REG_MCR: rsp.read_data = cur.mcr;
          REG_LSR: begin
            lsr_v              = cur.lsr | LSR_THR_IDLE;
            rsp.read_data      = lsr_v;
            nxt.lsr            = ((lsr_v & LSR_ERR_MASK) != 8'h00) ? (lsr_v & LSR_ERR_CLR)
                                                                   : lsr_v;
            nxt.pend[PEND_RLS] = 1'b0;
            eval               = 1'b1;
          end
          REG_MSR: begin
            msr_v = cur.msr;
            // loopback: mcr low nibble drives the modem inputs
            if (cur.mcr[MCR_LOOP]) begin
              msr_v = {cur.mcr[3:0], cur.msr[7:4] ^ cur.mcr[3:0]};
            end
            rsp.read_data      = msr_v;
            nxt.msr            = {msr_v[7:4], 4'h0};
            nxt.pend[PEND_MSR] = 1'b0;
            eval               = 1'b1;
          end
          REG_SCR: rsp.read_data = cur.scr;
          default: ;
        endcase
      end
      REQ_RX: begin
        lsr_v = cur.lsr;
        if ({cur.div_hi, cur.div_lo} != exp_div) begin
          lsr_v[LSR_FE] = 1'b1;
        end
        if (cur.lsr[LSR_DR]) begin
          lsr_v[LSR_OE] = 1'b1;
        end
        lsr_v[LSR_DR]      = 1'b1;
        nxt.lsr            = lsr_v;
        nxt.rbr            = req.data;
        nxt.pend[PEND_RDA] = 1'b1;
        eval               = 1'b1;
      end
      REQ_MSI: begin
        if (msr_chg != 4'h0) begin
          nxt.msr            = {req.data[7:4], msr_chg};
          nxt.pend[PEND_MSR] = 1'b1;
          eval               = 1'b1;
        end
      end
      default: ;
    endcase

    // interrupt priority, only while out2 is set
    if (eval && nxt.mcr[MCR_OUT2]) begin
      act            = nxt.pend & nxt.ier[3:0];
      rsp.irq_update = 1'b1;
      rsp.irq_level  = (act != 4'h0);
      priority if (act[PEND_RLS]) begin
        nxt.iir = IIR_RLS;
      end else if (act[PEND_RDA]) begin
        nxt.iir = IIR_RDA;
      end else if (act[PEND_THRE]) begin
        nxt.iir = IIR_THRE;
      end else if (act[PEND_MSR]) begin
        nxt.iir = IIR_MSR;
      end else begin
        nxt.iir = IIR_NONE;
      end
    end
  end

endmodule
